// File: sv/irqot_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irqot_pkg: shared types and constants of the interrupt ownership table
// Holds the command and status codes and the request and response beats.
// ----------------------------------------------------------------------------
package irqot_pkg;

  localparam int LINE_W = 4;
  localparam int TASK_W = 16;
  localparam int MASK_W = 16;
  localparam int LINE_SPAN = 1 << LINE_W;

  typedef enum logic [1:0] {
    CMD_REGISTER = 2'd0,
    CMD_RELEASE  = 2'd1,
    CMD_EVENT    = 2'd2,
    CMD_POLL     = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_LINE = 2'd1,
    ST_NO_RIGHT = 2'd2,
    ST_OWNED    = 2'd3
  } status_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [LINE_W-1:0] irq_line;
    logic [TASK_W-1:0] task_id;
    logic [MASK_W-1:0] rights_mask;
    logic              delivery_ok;
  } req_t;

  typedef struct packed {
    status_t           status;
    logic              notify_owner;
    logic [TASK_W-1:0] owner_out;
    logic [LINE_W-1:0] poll_line;
    logic              eoi_master;
    logic              eoi_slave;
  } rsp_t;

endpackage

// File: sv/irq_ownership_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irq_ownership_table: interrupt line ownership and pending-count table
// Register, release, event and poll commands on a table of owned lines.
// ----------------------------------------------------------------------------
//  channel  direction  handshake             beat
//  req      in         req_valid, req_stall  irqot_pkg::req_t
//  rsp      out        rsp_valid, rsp_stall  irqot_pkg::rsp_t
//
// One request beat is accepted in every cycle while req_stall is low. The
// accepting edge loads the input register. From there the beat moves through
// the table logic into the result register, where the table is updated and
// from which the response is offered. Reset clears the owned bits, the pending
// counts and both valid flags. A stalled response holds the input register,
// and req_stall rises only while both registers are full.
module irq_ownership_table #(
  parameter int NUM_LINES   = 16,
  parameter int COUNT_WIDTH = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  irqot_pkg::req_t req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output irqot_pkg::rsp_t rsp
);

  localparam int TABLE_LINES =
    (NUM_LINES < irqot_pkg::LINE_SPAN) ? NUM_LINES : irqot_pkg::LINE_SPAN;

  logic                             item_valid;
  irqot_pkg::req_t                  item;
  logic                             out_free;
  logic                             advance;
  logic                             accept;

  logic [TABLE_LINES-1:0]           owned;
  logic [TABLE_LINES-1:0]           owned_next;
  logic [irqot_pkg::TASK_W-1:0]     owner [TABLE_LINES];
  logic [TABLE_LINES-1:0]           owner_we;
  logic [COUNT_WIDTH-1:0]           count [TABLE_LINES];
  logic [COUNT_WIDTH-1:0]           count_next [TABLE_LINES];

  logic [TABLE_LINES-1:0]           hit;
  logic [TABLE_LINES-1:0]           match;
  logic [TABLE_LINES-1:0]           cand;
  logic [TABLE_LINES-1:0]           pick;
  logic                             in_range;
  logic                             hit_owned;
  logic [irqot_pkg::TASK_W-1:0]     hit_owner;
  logic [irqot_pkg::LINE_W-1:0]     pick_line;
  irqot_pkg::rsp_t                  rsp_next;

  assign out_free  = !rsp_valid || !rsp_stall;
  assign advance   = item_valid && out_free;
  assign req_stall = item_valid && !out_free;
  assign accept    = req_valid && !req_stall;

  always_comb begin
    in_range  = (32'(item.irq_line) < NUM_LINES);
    hit_owner = '0;
    pick_line = '0;
    for (int i = 0; i < TABLE_LINES; i++) begin
      hit[i]   = (item.irq_line == irqot_pkg::LINE_W'(i));
      match[i] = owned[i] && (owner[i] == item.task_id);
      cand[i]  = match[i] && (count[i] != '0);
    end
    hit_owned = |(hit & owned);
    pick      = cand & (~cand + TABLE_LINES'(1));
    for (int i = 0; i < TABLE_LINES; i++) begin
      if (hit[i] && owned[i]) begin
        hit_owner = hit_owner | owner[i];
      end
      if (pick[i]) begin
        pick_line = pick_line | irqot_pkg::LINE_W'(i);
      end
    end

    rsp_next   = '0;
    owned_next = owned;
    owner_we   = '0;
    count_next = count;
    case (item.cmd)
      irqot_pkg::CMD_REGISTER: begin
        if (item.irq_line == '0 || !in_range) begin
          rsp_next.status = irqot_pkg::ST_BAD_LINE;
        end else if (!item.rights_mask[item.irq_line]) begin
          rsp_next.status = irqot_pkg::ST_NO_RIGHT;
        end else if (hit_owned) begin
          rsp_next.status = irqot_pkg::ST_OWNED;
        end else begin
          owner_we   = hit;
          owned_next = owned | hit;
          for (int i = 0; i < TABLE_LINES; i++) begin
            if (hit[i]) begin
              count_next[i] = '0;
            end
          end
        end
      end
      irqot_pkg::CMD_RELEASE: begin
        owned_next = owned & ~match;
        for (int i = 0; i < TABLE_LINES; i++) begin
          if (match[i]) begin
            count_next[i] = '0;
          end
        end
      end
      irqot_pkg::CMD_EVENT: begin
        if (!in_range) begin
          rsp_next.status = irqot_pkg::ST_BAD_LINE;
        end else if (hit_owned) begin
          rsp_next.notify_owner = 1'b1;
          rsp_next.owner_out    = hit_owner;
          for (int i = 0; i < TABLE_LINES; i++) begin
            if (hit[i] && owned[i] && !item.delivery_ok && count[i] != '1) begin
              count_next[i] = count[i] + COUNT_WIDTH'(1);
            end
          end
        end
        rsp_next.eoi_master = 1'b1;
        rsp_next.eoi_slave  = item.irq_line[irqot_pkg::LINE_W-1];
      end
      irqot_pkg::CMD_POLL: begin
        rsp_next.poll_line = pick_line;
        for (int i = 0; i < TABLE_LINES; i++) begin
          if (pick[i]) begin
            count_next[i] = count[i] - COUNT_WIDTH'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      if (accept) begin
        item_valid <= 1'b1;
      end else if (advance) begin
        item_valid <= 1'b0;
      end
      if (out_free) begin
        rsp_valid <= item_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= req;
    end
    if (advance) begin
      rsp <= rsp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owned <= '0;
      for (int i = 0; i < TABLE_LINES; i++) begin
        count[i] <= '0;
      end
    end else if (advance) begin
      owned <= owned_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < TABLE_LINES; i++) begin
        if (owner_we[i]) begin
          owner[i] <= item.task_id;
        end
      end
    end
  end

  // Line zero can never be claimed.
  a_line_zero_free: assert property (@(posedge clk) disable iff (rst) !owned[0])
    else $error("line zero became owned");

  // At most one line is picked by a poll.
  a_pick_onehot: assert property (@(posedge clk) disable iff (rst) $onehot0(pick))
    else $error("poll picked more than one line");

  // A notified owner always comes with an end-of-interrupt to the master.
  a_notify_eoi: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.notify_owner |-> rsp.eoi_master)
    else $error("owner notified without end-of-interrupt");

  // A polled line is reported only by a successful poll, never by an event.
  a_poll_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.poll_line != '0 |->
      rsp.status == irqot_pkg::ST_OK && !rsp.eoi_master && !rsp.notify_owner)
    else $error("poll line reported outside a poll");

endmodule
